[design/cdc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types and constants of the 3x3 convolution with divide and clamp.
// ----------------------------------------------------------------------------
package cdc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 11;
   localparam int SUM_W      = 20;

   localparam logic [2:0] REG_COEFF_TOP    = 3'd0;
   localparam logic [2:0] REG_COEFF_MIDDLE = 3'd1;
   localparam logic [2:0] REG_COEFF_BOTTOM = 3'd2;
   localparam logic [2:0] REG_DIVISOR      = 3'd3;
   localparam logic [2:0] REG_WIDTH        = 3'd4;
   localparam logic [2:0] REG_HEIGHT       = 3'd5;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [23:0] data;
   } csr_type;

   // Window values and position that travel from the front end to the math.
   typedef struct packed {
      logic [8:0][7:0] win;
      logic [9:0]      row;
      logic [9:0]      col;
      logic            last;
   } job_type;

endpackage
`default_nettype wire

[design/cdc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_front
// Line stores, window and position counters. A pixel is read from both line
// stores at its column in the same cycle, then completed and written back.
// ----------------------------------------------------------------------------
module cdc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire cdc_pkg::req_type  in_word,
   output logic                   in_ready,
   input  wire logic [10:0]       width,
   input  wire logic [10:0]       height,
   output logic                   job_valid,
   output cdc_pkg::job_type       job,
   input  wire logic              job_ready
);
   import cdc_pkg::*;

   logic [7:0] upper_mem [MAX_WIDTH];
   logic [7:0] middle_mem [MAX_WIDTH];
   logic [7:0] up_rd, mid_rd;

   logic [SIZE_W-1:0] col_ff, col_in, row_ff, row_in;
   logic              busy_ff, busy_in;
   logic [SIZE_W-1:0] c_ff, r_ff;
   logic [7:0]        px_ff;
   logic [5:0][7:0]   win_ff, win_in;
   logic              jv_ff, jv_in;
   job_type           job_ff, job_in;
   logic [SIZE_W-1:0] w, h, c, r, cn, rn;
   logic              take, fire;

   always_comb begin
      w = (width < 11'd3) ? 11'd3 : (width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width;
      h = (height < 11'd3) ? 11'd3 :
          (height > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height;
   end

   assign in_ready = !busy_ff && !(jv_ff && !job_ready);
   assign take = in_valid && in_ready;
   assign c = in_word.frame_start ? '0 : col_ff;
   assign r = in_word.frame_start ? '0 : row_ff;

   always_ff @(posedge clock) begin
      if (take && c < 11'(MAX_WIDTH)) begin
         up_rd  <= upper_mem[c[COL_W-1:0]];
         mid_rd <= middle_mem[c[COL_W-1:0]];
      end
      if (busy_ff && c_ff < 11'(MAX_WIDTH)) begin
         upper_mem[c_ff[COL_W-1:0]]  <= mid_rd;
         middle_mem[c_ff[COL_W-1:0]] <= px_ff;
      end
      if (take) begin
         c_ff  <= c;
         r_ff  <= r;
         px_ff <= in_word.pixel;
      end
   end

   always_comb begin
      cn = c_ff + 11'd1;
      rn = r_ff;
      if (cn >= w) begin
         cn = '0;
         rn = r_ff + 11'd1;
      end
      if (rn >= h) rn = '0;
   end

   assign fire = busy_ff && c_ff >= 11'd2 && r_ff >= 11'd2 && c_ff < w && r_ff < h;

   always_comb begin
      busy_in = take;
      col_in  = busy_ff ? cn : col_ff;
      row_in  = busy_ff ? rn : row_ff;
      win_in  = win_ff;
      jv_in   = jv_ff && !job_ready;
      job_in  = job_ff;
      if (busy_ff) begin
         win_in = {px_ff, win_ff[5], mid_rd, win_ff[3], up_rd, win_ff[1]};
         if (fire) begin
            jv_in      = 1'b1;
            job_in.win = {px_ff, win_ff[5:4], mid_rd, win_ff[3:2], up_rd, win_ff[1:0]};
            job_in.row = 10'(r_ff - 11'd1);
            job_in.col = 10'(c_ff - 11'd1);
            job_in.last = (r_ff == h - 11'd1) && (c_ff == w - 11'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         busy_ff <= 1'b0;
         win_ff  <= '0;
         jv_ff   <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         busy_ff <= busy_in;
         win_ff  <= win_in;
         jv_ff   <= jv_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = jv_ff;
   assign job = job_ff;
endmodule
`default_nettype wire

[design/cdc_math.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_math
// Weighted sum of the window, bit-serial division by the divisor toward zero,
// clamp to 0..255 and the output register.
// ----------------------------------------------------------------------------
module cdc_math (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire cdc_pkg::job_type  job,
   output logic                   job_ready,
   input  wire logic [8:0][7:0]   coeff,
   input  wire logic [7:0]        divisor,
   output logic                   out_valid,
   output cdc_pkg::rsp_type       out_word,
   input  wire logic              out_stall
);
   import cdc_pkg::*;

   typedef enum logic [1:0] {IDLE, SUM, DIVIDE, DONE} state_type;

   state_type         state_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              neg_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [8:0]        rem_ff;
   logic [4:0]        cnt_ff;
   logic [9:0]        row_ff, col_ff;
   logic              last_ff;
   logic              ov_ff;
   rsp_type           out_ff;
   logic signed [SUM_W-1:0] acc;
   logic [7:0]        d;
   logic [8:0]        trial;
   logic [7:0]        q8;

   always_comb begin
      acc = '0;
      for (int k = 0; k < 9; k++) begin
         acc = acc + SUM_W'($signed({1'b0, job.win[k]}) * $signed(coeff[k]));
      end
   end

   assign d = (divisor == 8'd0) ? 8'd1 : divisor;
   assign trial = {rem_ff[7:0], sum_ff[SUM_W-1]};
   assign q8 = (neg_ff || quo_ff == '0) ? 8'd0 : (quo_ff > 20'd255) ? 8'd255 : quo_ff[7:0];
   assign job_ready = (state_ff == IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ov_ff    <= 1'b0;
      end else begin
         if (state_ff == DONE) begin
            if (!ov_ff || !out_stall) ov_ff <= 1'b1;
         end else if (!out_stall) begin
            ov_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  neg_ff  <= acc[SUM_W-1];
                  sum_ff  <= acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
                  row_ff  <= job.row;
                  col_ff  <= job.col;
                  last_ff <= job.last;
                  state_ff <= SUM;
               end
            end
            SUM: begin
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               sum_ff <= sum_ff << 1;
               if (trial >= {1'b0, d}) begin
                  rem_ff <= trial - {1'b0, d};
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial;
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(SUM_W - 1)) state_ff <= DONE;
            end
            DONE: begin
               if (!ov_ff || !out_stall) begin
                  out_ff   <= '{filtered: q8, out_row: row_ff, out_col: col_ff,
                                frame_last: last_ff};
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign out_valid = ov_ff;
   assign out_word = out_ff;
endmodule
`default_nettype wire

[design/conv3x3_divide_clamp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp
// 3x3 convolution of an 8-bit pixel stream with divide and clamp.
//
// Pixels arrive in raster order on the req_ channel, one word per handshake;
// frame_start marks the first pixel of a plane. Each interior pixel gives one
// word on the rsp_ channel with its row and column; frame_last marks the last
// interior pixel. Border pixels give no word. Registers must be written on the
// csr_ channel while the block is idle; the block does not enforce this.
// Each pixel passes through the line-store read/modify/write. An interior
// pixel then goes through the sum and the 20-step serial divider, which
// takes no new window until its result is in the output register; border
// pixels only pass the read/modify/write.
// After reset the coefficients pass the middle-row pixel right of the center,
// divisor is 1 and the size is 1024 by 1024. A stalled result holds and the
// divider keeps its next result until the output register is free; the input
// stalls during write-back and while a window waits for the busy divider.
// ----------------------------------------------------------------------------
module conv3x3_divide_clamp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cdc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cdc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire cdc_pkg::csr_type csr_data
);
   import cdc_pkg::*;

   logic [23:0] top_ff, mid_ff, bot_ff;
   logic [7:0]  div_ff;
   logic [10:0] width_ff, height_ff;
   logic        in_ready, job_valid, job_ready;
   job_type     job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '0;
         mid_ff    <= 24'h010000;
         bot_ff    <= '0;
         div_ff    <= 8'd1;
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
      end else if (csr_valid) begin
         unique case (csr_data.index)
            REG_COEFF_TOP:    top_ff    <= csr_data.data;
            REG_COEFF_MIDDLE: mid_ff    <= csr_data.data;
            REG_COEFF_BOTTOM: bot_ff    <= csr_data.data;
            REG_DIVISOR:      div_ff    <= csr_data.data[7:0];
            REG_WIDTH:        width_ff  <= csr_data.data[10:0];
            REG_HEIGHT:       height_ff <= csr_data.data[10:0];
            default: ;
         endcase
      end
   end

   assign req_stall = !in_ready;

   cdc_front u_front (
      .clock, .reset,
      .in_valid (req_valid),
      .in_word  (req_data),
      .in_ready (in_ready),
      .width    (width_ff),
      .height   (height_ff),
      .job_valid(job_valid),
      .job      (job),
      .job_ready(job_ready)
   );

   cdc_math u_math (
      .clock, .reset,
      .job_valid(job_valid),
      .job      (job),
      .job_ready(job_ready),
      .coeff    ({bot_ff, mid_ff, top_ff}),
      .divisor  (div_ff),
      .out_valid(rsp_valid),
      .out_word (rsp_data),
      .out_stall(rsp_stall)
   );
endmodule
`default_nettype wire

[dv/conv3x3_divide_clamp_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp_test
// Self-checking bench for the 3x3 convolution with divide and clamp.
//
// Small frames are streamed under several kernel, divisor and size settings,
// including the extremes. Each pixel word is run through a local model of the
// line stores and window, and every result word is compared in order against
// the predicted value, row, column and last mark.
// ----------------------------------------------------------------------------
module conv3x3_divide_clamp_test;
   import cdc_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   csr_type csr_data;

   conv3x3_divide_clamp i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   logic [23:0] kern_row [3];
   logic [7:0]  div_reg;
   logic [10:0] width_reg;
   logic [10:0] height_reg;
   logic [7:0]  upper_mem [MAX_WIDTH];
   logic [7:0]  middle_mem [MAX_WIDTH];
   logic [7:0]  win_cols [6];
   int          col_pos;
   int          row_pos;

   req_type pixel_queue [$];
   rsp_type filtered_queue [$];
   int      errors;
   int      words_sent;
   int      words_checked;
   int      frames_sent;
   bit      burst_on;
   int      burst_left;
   bit      req_accepted;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int kern_weight(logic [23:0] r, int k);
      logic signed [7:0] b;
      b = r[8*k +: 8];
      return int'(b);
   endfunction

   function automatic int size_limit(logic [10:0] v, int maxv);
      if (v < 3) return 3;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   task automatic predict_pixel(req_type p);
      int      w;
      int      h;
      int      sum;
      int      q;
      int      d;
      logic [7:0] up;
      logic [7:0] mid;
      logic [7:0] cur [3];
      rsp_type e;
      w = size_limit(width_reg, MAX_WIDTH);
      h = size_limit(height_reg, MAX_HEIGHT);
      if (p.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      up = upper_mem[col_pos];
      mid = middle_mem[col_pos];
      if (col_pos >= 2 && row_pos >= 2 && col_pos < w && row_pos < h) begin
         cur[0] = up; cur[1] = mid; cur[2] = p.pixel;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            sum += int'(win_cols[2*i]) * kern_weight(kern_row[i], 0);
            sum += int'(win_cols[2*i+1]) * kern_weight(kern_row[i], 1);
            sum += int'(cur[i]) * kern_weight(kern_row[i], 2);
         end
         d = (div_reg == 0) ? 1 : int'(div_reg);
         q = sum / d;
         if (q < 0) q = 0;
         if (q > 255) q = 255;
         e.filtered = q[7:0];
         e.out_row = 10'(row_pos - 1);
         e.out_col = 10'(col_pos - 1);
         e.frame_last = (row_pos == h - 1 && col_pos == w - 1);
         filtered_queue.push_back(e);
      end
      win_cols[0] = win_cols[1]; win_cols[1] = up;
      win_cols[2] = win_cols[3]; win_cols[3] = mid;
      win_cols[4] = win_cols[5]; win_cols[5] = p.pixel;
      upper_mem[col_pos] = mid;
      middle_mem[col_pos] = p.pixel;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
   endtask

   // Driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (burst_left == 0) begin
            burst_on = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 30);
         end
         burst_left--;
         if (pixel_queue.size() > 0 && burst_on) begin
            req_data <= pixel_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      case ($urandom_range(0, 9))
         0, 1, 2: rsp_stall <= ($urandom_range(0, 1) == 1);
         default: rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_pixel(req_data);
         words_sent++;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_queue.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_data);
            errors++;
         end else begin
            e = filtered_queue.pop_front();
            words_checked++;
            if (e.filtered !== rsp_data.filtered)
               $display("%0t: filtered exp %0d got %0d", $time, e.filtered,
                        rsp_data.filtered);
            if (e.out_row !== rsp_data.out_row)
               $display("%0t: out_row exp %0d got %0d", $time, e.out_row,
                        rsp_data.out_row);
            if (e.out_col !== rsp_data.out_col)
               $display("%0t: out_col exp %0d got %0d", $time, e.out_col,
                        rsp_data.out_col);
            if (e.frame_last !== rsp_data.frame_last)
               $display("%0t: frame_last exp %0d got %0d", $time, e.frame_last,
                        rsp_data.frame_last);
            if (e !== rsp_data) errors++;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_data <= '{index: idx, data: val};
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_COEFF_TOP:    kern_row[0] = val;
         REG_COEFF_MIDDLE: kern_row[1] = val;
         REG_COEFF_BOTTOM: kern_row[2] = val;
         REG_DIVISOR:      div_reg = val[7:0];
         REG_WIDTH:        width_reg = val[10:0];
         REG_HEIGHT:       height_reg = val[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pixel_queue.size() > 0 || req_valid || filtered_queue.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic queue_frame(int w, int h, int mode);
      req_type p;
      for (int i = 0; i < w * h; i++) begin
         p.frame_start = (i == 0);
         case (mode)
            0: p.pixel = 8'hFF;
            1: p.pixel = 8'h00;
            default: p.pixel = 8'($urandom_range(0, 255));
         endcase
         pixel_queue.push_back(p);
      end
      frames_sent++;
   endtask

   task automatic setup(logic [23:0] k0, logic [23:0] k1, logic [23:0] k2,
                        logic [7:0] dv, logic [10:0] w, logic [10:0] h);
      write_reg(REG_COEFF_TOP, k0);
      write_reg(REG_COEFF_MIDDLE, k1);
      write_reg(REG_COEFF_BOTTOM, k2);
      write_reg(REG_DIVISOR, 24'(dv));
      write_reg(REG_WIDTH, 24'(w));
      write_reg(REG_HEIGHT, 24'(h));
   endtask

   initial begin
      int w;
      int h;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      frames_sent = 0;
      burst_left = 0;
      burst_on = 1'b1;
      kern_row[0] = 24'h0; kern_row[1] = 24'h010000; kern_row[2] = 24'h0;
      div_reg = 8'd1;
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_mem[i] = 8'h00;
         middle_mem[i] = 8'h00;
      end
      foreach (win_cols[i]) win_cols[i] = 8'h00;
      col_pos = 0;
      row_pos = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extreme weights, full saturation both ways, zero divisor, small sizes.
      setup(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0, 11'd0, 11'd2);
      queue_frame(3, 3, 0);
      queue_frame(3, 3, 2);
      drain();
      setup(24'h808080, 24'h808080, 24'h808080, 8'd255, 11'd4, 11'd3);
      queue_frame(4, 3, 0);
      drain();
      setup(24'h00FF00, 24'hFF08FF, 24'h00FF00, 8'd255, 11'd5, 11'd4);
      queue_frame(5, 4, 1);
      drain();

      // Random kernels and small frames; one stream runs on without a start mark.
      while (words_sent < 420) begin
         w = $urandom_range(3, 8);
         h = $urandom_range(3, 6);
         setup(24'($urandom), 24'($urandom), 24'($urandom),
               8'($urandom_range(0, 255)), 11'(w), 11'(h));
         queue_frame(w, h, 2);
         queue_frame(w, h, 2);
         for (int i = 0; i < w * h; i++)
            pixel_queue.push_back('{pixel: 8'($urandom_range(0, 255)),
                                   frame_start: 1'b0});
         drain();
      end

      $display("Covered %0d pixel words in %0d frames, %0d results checked.",
               words_sent, frames_sent, words_checked);
      if (errors == 0 && filtered_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
